>>> rtl/core/hrl_pkg.sv
// Types, constants and helper functions shared by the hex record line parser.
// Depends on nothing; every parser file but hrl_ram uses it by scoped names.
`default_nettype none

package hrl_pkg;

  // line geometry
  localparam int LINE_CHARS = 40;
  localparam int BYTE_COUNT = LINE_CHARS / 2;
  localparam int LEN_W      = $clog2(LINE_CHARS + 2);
  localparam int BIDX_W     = $clog2(BYTE_COUNT);

  // field widths of the result word
  localparam int STATUS_W   = 2;
  localparam int DATA_W     = 8;
  localparam int BYTE_IDX_W = 5;
  localparam int LINE_NUM_W = 24;
  localparam int ERR_POS_W  = 6;
  localparam int CNT_W      = 17;
  localparam int TAIL_W     = 16;

  // line buffer: two banks, each addressed by byte index
  localparam int RAM_AW    = BIDX_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  // job queue between front and back
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  typedef logic [LEN_W-1:0] len_t;

  localparam len_t LINE_LEN = LEN_W'(LINE_CHARS);
  localparam len_t LEN_CAP  = LEN_W'(LINE_CHARS + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_DATA     = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_BAD_CHAR = 2'd2,
    ST_BAD_SEQ  = 2'd3
  } status_e;

  // one finished line handed from front to back
  typedef struct packed {
    status_e                 status;
    logic [LINE_NUM_W-1:0]   line_number;
    logic [ERR_POS_W-1:0]    err_pos;
    logic                    bank;
  } hrl_job_t;

  // line buffer write port
  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } hrl_wr_t;

  // line buffer read port
  typedef struct packed {
    logic              re;
    logic [RAM_AW-1:0] addr;
  } hrl_rd_t;

  // saturate a length at one past the line length
  function automatic len_t cap_len(input logic [LEN_W:0] x);
    len_t r;
    if (x > {1'b0, LEN_CAP}) begin
      r = LEN_CAP;
    end else begin
      r = x[LEN_W-1:0];
    end
    return r;
  endfunction

  // hex digit value, bit 4 set for a non-hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

  // blank, tab and the other control whitespace codes
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/hrl_if.sv
// Channel interfaces of the parser: character words in, result words out.
// Depends on hrl_pkg for the field widths.
`default_nettype none

interface hrl_char_if;
  logic                       valid;
  logic                       ready;
  logic [hrl_pkg::DATA_W-1:0] char_code;
  logic                       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface hrl_res_if;
  logic                           valid;
  logic                           ready;
  logic [hrl_pkg::STATUS_W-1:0]   status;
  logic [hrl_pkg::DATA_W-1:0]     data_byte;
  logic [hrl_pkg::BYTE_IDX_W-1:0] byte_index;
  logic [hrl_pkg::LINE_NUM_W-1:0] line_number;
  logic [hrl_pkg::ERR_POS_W-1:0]  error_position;
  logic                           last;

  modport source (output valid, output status, output data_byte, output byte_index,
                  output line_number, output error_position, output last, input ready);
  modport sink   (input valid, input status, input data_byte, input byte_index,
                  input line_number, input error_position, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/hex_record_line_parser.sv
// Hex record line parser, top level: front end, job queue, line buffer, back end.
// Characters are taken one per cycle; ready drops only while two finished lines wait.
// A valid line's 20 bytes leave one per cycle while the result channel takes them; a line
// ended by newline or end of input passes the two-entry job queue, the read stage and the
// output register. An error word takes the same path and halts the parser until reset.
// Asynchronous active-low reset clears all control state; the line buffer needs no clear.
`default_nettype none

module hex_record_line_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hrl_char_if.sink  in_i,
  hrl_res_if.source out_o
);

  logic                       push;
  logic                       pop;
  logic                       q_full;
  logic                       q_empty;
  hrl_pkg::hrl_job_t          job;
  hrl_pkg::hrl_job_t          head;
  hrl_pkg::hrl_wr_t           wr;
  hrl_pkg::hrl_rd_t           rd;
  logic [hrl_pkg::DATA_W-1:0] rdata;

  hrl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job),
    .wr_o     (wr)
  );

  hrl_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // two banks of line bytes
  hrl_ram #(
    .WIDTH (hrl_pkg::DATA_W),
    .DEPTH (hrl_pkg::RAM_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd.re),
    .raddr_i (rd.addr),
    .rdata_o (rdata)
  );

  hrl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (head),
    .pop_o   (pop),
    .rd_o    (rd),
    .rdata_i (rdata),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/hrl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module hrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hrl_front.sv
// Front end: takes characters, tracks comments, trimming and line checks,
// writes decoded bytes to the line buffer, queues a job per record line.
// Depends on hrl_pkg and hrl_char_if.
`default_nettype none

module hrl_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  hrl_char_if.sink               in_i,
  input  wire logic              q_full_i,
  output      logic              push_o,
  output      hrl_pkg::hrl_job_t job_o,
  output      hrl_pkg::hrl_wr_t  wr_o
);

  logic                               halted_q, halted_d;
  logic [hrl_pkg::LINE_NUM_W-1:0]     line_count_q, line_count_d;
  logic [hrl_pkg::CNT_W-1:0]          expected_q, expected_d;
  hrl_pkg::len_t                      kept_q, kept_d;
  hrl_pkg::len_t                      pend_q, pend_d;
  hrl_pkg::len_t                      bad_pos_q, bad_pos_d;
  logic                               bad_seen_q, bad_seen_d;
  logic                               in_comment_q, in_comment_d;
  logic                               hash_seen_q, hash_seen_d;
  logic                               header_q, header_d;
  logic [3:0]                         high_q, high_d;
  logic                               started_q, started_d;
  logic                               lead_dollar_q, lead_dollar_d;
  logic [hrl_pkg::TAIL_W-1:0]         tail_q, tail_d;
  logic                               wr_bank_q, wr_bank_d;

  logic                               acc;
  logic                               line_end;
  logic                               take;
  logic [7:0]                         ch;
  logic [4:0]                         nib;
  logic                               is_header;
  logic [hrl_pkg::LINE_NUM_W-1:0]     line_next;
  hrl_pkg::status_e                   line_status;
  hrl_pkg::len_t                      k_len;
  logic                               bs;
  hrl_pkg::len_t                      bp;

  // accept a word whenever the job queue has room
  assign in_i.ready = !q_full_i;
  assign acc        = in_i.valid && in_i.ready && !halted_q;
  assign ch         = in_i.char_code;
  assign nib        = hrl_pkg::hex_value(ch);
  assign line_end   = acc && (in_i.end_of_input ? started_q : (ch == hrl_pkg::CH_NL));
  assign take       = acc && !in_i.end_of_input && (ch != hrl_pkg::CH_NL);

  // line verdict, evaluated at the line end
  assign is_header = header_q || (lead_dollar_q && !in_comment_q);
  assign line_next = (line_count_q == '1) ? line_count_q : line_count_q + 1'b1;

  always_comb begin
    if (kept_q != hrl_pkg::LINE_LEN) begin
      line_status = hrl_pkg::ST_BAD_LEN;
    end else if (bad_seen_q) begin
      line_status = hrl_pkg::ST_BAD_CHAR;
    end else if ({1'b0, tail_q} != expected_q) begin
      line_status = hrl_pkg::ST_BAD_SEQ;
    end else begin
      line_status = hrl_pkg::ST_DATA;
    end
  end

  assign push_o            = line_end && !is_header && (kept_q != '0);
  assign job_o.status      = line_status;
  assign job_o.line_number = line_next;
  assign job_o.err_pos     = (line_status == hrl_pkg::ST_BAD_CHAR) ?
                             hrl_pkg::ERR_POS_W'(bad_pos_q) : '0;
  assign job_o.bank        = wr_bank_q;

  // per-character and per-line state update
  always_comb begin
    halted_d      = halted_q;
    line_count_d  = line_count_q;
    expected_d    = expected_q;
    kept_d        = kept_q;
    pend_d        = pend_q;
    bad_pos_d     = bad_pos_q;
    bad_seen_d    = bad_seen_q;
    in_comment_d  = in_comment_q;
    hash_seen_d   = hash_seen_q;
    header_d      = header_q;
    high_d        = high_q;
    started_d     = started_q;
    lead_dollar_d = lead_dollar_q;
    tail_d        = tail_q;
    wr_bank_d     = wr_bank_q;
    wr_o          = '0;
    k_len         = kept_q;
    bs            = bad_seen_q;
    bp            = bad_pos_q;

    if (line_end) begin
      line_count_d  = line_next;
      kept_d        = '0;
      pend_d        = '0;
      bad_pos_d     = '0;
      bad_seen_d    = 1'b0;
      in_comment_d  = 1'b0;
      hash_seen_d   = 1'b0;
      header_d      = 1'b0;
      high_d        = '0;
      started_d     = 1'b0;
      lead_dollar_d = 1'b0;
      tail_d        = '0;
      if (push_o) begin
        if (line_status == hrl_pkg::ST_DATA) begin
          expected_d = {1'b0, tail_q} + 1'b1;
          wr_bank_d  = !wr_bank_q;
        end else begin
          halted_d = 1'b1;
        end
      end
    end else if (take) begin
      started_d = 1'b1;
      if (in_comment_q) begin
        // only the character right after the hash can mark a header line
        if (hash_seen_q && ch == hrl_pkg::CH_DOLLAR) begin
          header_d = 1'b1;
        end
        hash_seen_d = 1'b0;
      end else if (ch == hrl_pkg::CH_HASH) begin
        in_comment_d = 1'b1;
        hash_seen_d  = 1'b1;
        pend_d       = '0;
      end else begin
        if (!started_q && ch == hrl_pkg::CH_DOLLAR) begin
          lead_dollar_d = 1'b1;
        end
        if (hrl_pkg::is_space(ch)) begin
          // whitespace is held back until a later character keeps it
          if (kept_q != '0) begin
            pend_d = hrl_pkg::cap_len({1'b0, pend_q} + 1'b1);
          end
        end else begin
          if (pend_q != '0) begin
            if (!bs && kept_q < hrl_pkg::LINE_LEN) begin
              bs = 1'b1;
              bp = kept_q;
            end
            k_len  = hrl_pkg::cap_len({1'b0, kept_q} + {1'b0, pend_q});
            pend_d = '0;
          end
          if (nib[4]) begin
            if (!bs && k_len < hrl_pkg::LINE_LEN) begin
              bs = 1'b1;
              bp = k_len;
            end
          end else if (k_len < hrl_pkg::LINE_LEN) begin
            tail_d = {tail_q[hrl_pkg::TAIL_W-5:0], nib[3:0]};
            if (!k_len[0]) begin
              high_d = nib[3:0];
            end else begin
              wr_o.we   = 1'b1;
              wr_o.addr = {wr_bank_q, k_len[hrl_pkg::BIDX_W:1]};
              wr_o.data = {high_q, nib[3:0]};
            end
          end
          kept_d     = hrl_pkg::cap_len({1'b0, k_len} + 1'b1);
          bad_seen_d = bs;
          bad_pos_d  = bp;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q      <= 1'b0;
      line_count_q  <= '0;
      expected_q    <= '0;
      kept_q        <= '0;
      pend_q        <= '0;
      bad_pos_q     <= '0;
      bad_seen_q    <= 1'b0;
      in_comment_q  <= 1'b0;
      hash_seen_q   <= 1'b0;
      header_q      <= 1'b0;
      high_q        <= '0;
      started_q     <= 1'b0;
      lead_dollar_q <= 1'b0;
      tail_q        <= '0;
      wr_bank_q     <= 1'b0;
    end else begin
      halted_q      <= halted_d;
      line_count_q  <= line_count_d;
      expected_q    <= expected_d;
      kept_q        <= kept_d;
      pend_q        <= pend_d;
      bad_pos_q     <= bad_pos_d;
      bad_seen_q    <= bad_seen_d;
      in_comment_q  <= in_comment_d;
      hash_seen_q   <= hash_seen_d;
      header_q      <= header_d;
      high_q        <= high_d;
      started_q     <= started_d;
      lead_dollar_q <= lead_dollar_d;
      tail_q        <= tail_d;
      wr_bank_q     <= wr_bank_d;
    end
  end

  // checks
  a_no_job_when_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !push_o && !wr_o.we)
    else $error("job or buffer write while halted");

  a_kept_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= hrl_pkg::LEN_CAP && pend_q <= hrl_pkg::LEN_CAP)
    else $error("line length beyond its cap");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && job_o.status != hrl_pkg::ST_DATA |=> halted_q)
    else $error("error line did not halt the parser");

endmodule

`default_nettype wire

>>> rtl/core/hrl_job_fifo.sv
// Short job queue between front and back; a data job keeps its buffer bank
// until the back end pops it. Depends on hrl_pkg.
`default_nettype none

module hrl_job_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire hrl_pkg::hrl_job_t job_i,
  output      logic              full_o,
  input  wire logic              pop_i,
  output      logic              empty_o,
  output      hrl_pkg::hrl_job_t head_o
);

  hrl_pkg::hrl_job_t                 entry_q [hrl_pkg::JOBQ_DEPTH];
  logic [hrl_pkg::JOBQ_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [hrl_pkg::JOBQ_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [hrl_pkg::JOBQ_CNT_W-1:0]    count_q, count_d;

  assign full_o  = (count_q == hrl_pkg::JOBQ_CNT_W'(hrl_pkg::JOBQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == hrl_pkg::JOBQ_PTR_W'(hrl_pkg::JOBQ_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == hrl_pkg::JOBQ_PTR_W'(hrl_pkg::JOBQ_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job popped from an empty queue");

endmodule

`default_nettype wire

>>> rtl/core/hrl_back.sv
// Back end: walks the head job, reads its bytes from the line buffer and
// drives the result channel through an output register. Depends on hrl_pkg, hrl_res_if.
`default_nettype none

module hrl_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       empty_i,
  input  wire hrl_pkg::hrl_job_t          head_i,
  output      logic                       pop_o,
  output      hrl_pkg::hrl_rd_t           rd_o,
  input  wire logic [hrl_pkg::DATA_W-1:0] rdata_i,
  hrl_res_if.source                       out_o
);

  // read stage: byte read issued, data arrives from the buffer
  logic                               s1_valid_q, s1_valid_d;
  hrl_pkg::status_e                   s1_status_q;
  logic [hrl_pkg::BIDX_W-1:0]         s1_idx_q;
  logic [hrl_pkg::LINE_NUM_W-1:0]     s1_line_q;
  logic [hrl_pkg::ERR_POS_W-1:0]      s1_err_q;
  logic                               s1_last_q;

  // output register
  logic                               out_valid_q, out_valid_d;
  logic [hrl_pkg::STATUS_W-1:0]       out_status_q;
  logic [hrl_pkg::DATA_W-1:0]         out_data_q;
  logic [hrl_pkg::BYTE_IDX_W-1:0]     out_idx_q;
  logic [hrl_pkg::LINE_NUM_W-1:0]     out_line_q;
  logic [hrl_pkg::ERR_POS_W-1:0]      out_err_q;
  logic                               out_last_q;

  logic [hrl_pkg::BIDX_W-1:0]         idx_q, idx_d;
  logic                               adv;
  logic                               issue;
  logic                               is_data;
  logic                               job_last;

  assign adv      = !out_valid_q || out_o.ready;
  assign issue    = adv && !empty_i;
  assign is_data  = (head_i.status == hrl_pkg::ST_DATA);
  assign job_last = !is_data || (idx_q == hrl_pkg::BIDX_W'(hrl_pkg::BYTE_COUNT - 1));
  assign pop_o    = issue && job_last;

  assign rd_o.re   = issue && is_data;
  assign rd_o.addr = {head_i.bank, idx_q};

  // byte walk over the head job
  always_comb begin
    idx_d = idx_q;
    if (issue) begin
      idx_d = job_last ? '0 : idx_q + 1'b1;
    end
  end

  assign s1_valid_d  = adv ? issue : s1_valid_q;
  assign out_valid_d = adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload of both stages
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_status_q <= head_i.status;
      s1_idx_q    <= is_data ? idx_q : '0;
      s1_line_q   <= head_i.line_number;
      s1_err_q    <= head_i.err_pos;
      s1_last_q   <= job_last;
    end
    if (adv && s1_valid_q) begin
      out_status_q <= s1_status_q;
      out_data_q   <= (s1_status_q == hrl_pkg::ST_DATA) ? rdata_i : '0;
      out_idx_q    <= hrl_pkg::BYTE_IDX_W'(s1_idx_q);
      out_line_q   <= s1_line_q;
      out_err_q    <= s1_err_q;
      out_last_q   <= s1_last_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.data_byte      = out_data_q;
  assign out_o.byte_index     = out_idx_q;
  assign out_o.line_number    = out_line_q;
  assign out_o.error_position = out_err_q;
  assign out_o.last           = out_last_q;

  // checks
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != hrl_pkg::ST_DATA |-> out_o.last)
    else $error("error word not marked last");

  a_last_byte_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == hrl_pkg::ST_DATA |->
      out_o.last == (out_o.byte_index == hrl_pkg::BYTE_IDX_W'(hrl_pkg::BYTE_COUNT - 1)))
    else $error("last flag does not match the final byte of a line");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench of the hex record line parser: drives character words,
// predicts every result word and compares them field by field. Needs hrl_pkg, hrl_if.sv
// and the parser top level.
`timescale 1ns / 100ps

module testbench;

  import hrl_pkg::*;

  localparam int unsigned RUN_LIMIT    = 300000;
  localparam int unsigned RANDOM_WORDS = 160;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned SHOW_LIMIT   = 50;

  typedef enum int unsigned {
    FAULT_SHORT,
    FAULT_LONG,
    FAULT_INNER_BLANK,
    FAULT_BAD_CHAR,
    FAULT_COUNTER
  } line_fault_e;

  typedef struct packed {
    status_e               status;
    logic [DATA_W-1:0]     data_byte;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic [LINE_NUM_W-1:0] line_number;
    logic [ERR_POS_W-1:0]  error_position;
    logic                  last;
  } parse_result_t;

  logic clk_i;
  logic rst_ni;

  hrl_char_if in_if ();
  hrl_res_if  out_if ();

  hex_record_line_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // run bookkeeping
  parse_result_t awaited_results[$];
  logic [7:0]    line_text[$];
  int unsigned   cycle_count;
  int unsigned   mismatch_count;
  int unsigned   words_sent;
  int unsigned   record_no;
  int unsigned   tx_idle_pct;
  int unsigned   rx_idle_pct;
  logic          stall_rx;

  // parser state as predicted
  bit                    p_halted;
  logic [LINE_NUM_W-1:0] p_line_count;
  logic [CNT_W-1:0]      p_next_counter;
  int unsigned           p_kept;
  int unsigned           p_spaces;
  int unsigned           p_bad_pos;
  bit                    p_bad;
  bit                    p_comment;
  bit                    p_hash_prev;
  bit                    p_header;
  bit                    p_started;
  bit                    p_dollar_lead;
  logic [TAIL_W-1:0]     p_tail;
  logic [3:0]            p_high;
  logic [DATA_W-1:0]     p_bytes[BYTE_COUNT];

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned clamp_len(int unsigned x);
    return (x > LINE_CHARS) ? LINE_CHARS + 1 : x;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    case (c)
      8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // 16 stands for a character that is no hex digit
  function automatic int unsigned digit_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
    return 16;
  endfunction

  function automatic void clear_line_state();
    p_kept        = 0;
    p_spaces      = 0;
    p_bad_pos     = 0;
    p_bad         = 1'b0;
    p_comment     = 1'b0;
    p_hash_prev   = 1'b0;
    p_header      = 1'b0;
    p_started     = 1'b0;
    p_dollar_lead = 1'b0;
    p_high        = '0;
    p_tail        = '0;
  endfunction

  function automatic void reset_prediction();
    p_halted       = 1'b0;
    p_line_count   = '0;
    p_next_counter = '0;
    foreach (p_bytes[k]) p_bytes[k] = '0;
    clear_line_state();
  endfunction

  function automatic void add_result(status_e st, logic [7:0] b, int unsigned idx,
                                     int unsigned pos, bit fin);
    parse_result_t r;
    r.status         = st;
    r.data_byte      = b;
    r.byte_index     = BYTE_IDX_W'(idx);
    r.line_number    = p_line_count;
    r.error_position = ERR_POS_W'(pos);
    r.last           = fin;
    awaited_results.push_back(r);
  endfunction

  // one character inside a line
  function automatic void take_line_char(logic [7:0] c);
    bit          first;
    int unsigned pos;
    int unsigned nib;
    first     = !p_started;
    p_started = 1'b1;
    if (p_comment) begin
      if (p_hash_prev && c == CH_DOLLAR) p_header = 1'b1;
      p_hash_prev = 1'b0;
      return;
    end
    if (c == CH_HASH) begin
      p_comment   = 1'b1;
      p_hash_prev = 1'b1;
      p_spaces    = 0;
      return;
    end
    if (first && c == CH_DOLLAR) p_dollar_lead = 1'b1;
    if (is_blank(c)) begin
      if (p_kept > 0) p_spaces = clamp_len(p_spaces + 1);
      return;
    end
    // blanks followed by more text sit inside the line
    if (p_spaces > 0) begin
      if (!p_bad && p_kept < LINE_CHARS) begin
        p_bad     = 1'b1;
        p_bad_pos = p_kept;
      end
      p_kept   = clamp_len(p_kept + p_spaces);
      p_spaces = 0;
    end
    pos = p_kept;
    nib = digit_value(c);
    if (nib > 15) begin
      if (!p_bad && pos < LINE_CHARS) begin
        p_bad     = 1'b1;
        p_bad_pos = pos;
      end
    end else if (pos < LINE_CHARS) begin
      p_tail = {p_tail[TAIL_W-5:0], 4'(nib)};
      if (pos % 2 == 0) p_high = 4'(nib);
      else p_bytes[pos / 2] = {p_high, 4'(nib)};
    end
    p_kept = clamp_len(p_kept + 1);
  endfunction

  // line end: checks in order length, characters, counter
  function automatic void finish_line();
    bit                skip;
    int unsigned       kept;
    int unsigned       bad_pos;
    bit                bad;
    logic [TAIL_W-1:0] tail;
    skip    = p_header || (p_dollar_lead && !p_comment);
    kept    = p_kept;
    bad_pos = p_bad_pos;
    bad     = p_bad;
    tail    = p_tail;
    if (p_line_count != '1) p_line_count = p_line_count + 1'b1;
    clear_line_state();
    if (skip || kept == 0) return;
    if (kept != LINE_CHARS) begin
      p_halted = 1'b1;
      add_result(ST_BAD_LEN, '0, 0, 0, 1'b1);
    end else if (bad) begin
      p_halted = 1'b1;
      add_result(ST_BAD_CHAR, '0, 0, bad_pos, 1'b1);
    end else if ({1'b0, tail} != p_next_counter) begin
      p_halted = 1'b1;
      add_result(ST_BAD_SEQ, '0, 0, 0, 1'b1);
    end else begin
      p_next_counter = {1'b0, tail} + 1'b1;
      for (int k = 0; k < BYTE_COUNT; k++) begin
        add_result(ST_DATA, p_bytes[k], k, 0, k == BYTE_COUNT - 1);
      end
    end
  endfunction

  // expected results of one accepted word
  function automatic void parse_word(logic [7:0] c, logic eoi);
    if (p_halted) return;
    if (eoi) begin
      if (p_started) finish_line();
    end else if (c == CH_NL) begin
      finish_line();
    end else begin
      take_line_char(c);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_result();
    parse_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result word, status %0d line %0d",
                                out_if.status, out_if.line_number));
      return;
    end
    want = awaited_results.pop_front();
    if (out_if.status !== want.status)
      report_mismatch($sformatf("line %0d: status %0d, wanted %0d",
                                want.line_number, out_if.status, want.status));
    if (out_if.data_byte !== want.data_byte)
      report_mismatch($sformatf("line %0d byte %0d: data %h, wanted %h", want.line_number,
                                want.byte_index, out_if.data_byte, want.data_byte));
    if (out_if.byte_index !== want.byte_index)
      report_mismatch($sformatf("line %0d: byte index %0d, wanted %0d",
                                want.line_number, out_if.byte_index, want.byte_index));
    if (out_if.line_number !== want.line_number)
      report_mismatch($sformatf("line number %0d, wanted %0d",
                                out_if.line_number, want.line_number));
    if (out_if.error_position !== want.error_position)
      report_mismatch($sformatf("line %0d: error position %0d, wanted %0d", want.line_number,
                                out_if.error_position, want.error_position));
    if (out_if.last !== want.last)
      report_mismatch($sformatf("line %0d byte %0d: last %b, wanted %b", want.line_number,
                                want.byte_index, out_if.last, want.last));
  endtask

  function automatic bit idle_now(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // result side: take words, random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) check_result();
    out_if.ready <= !stall_rx && !idle_now(rx_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic set_idling(int unsigned tx, int unsigned rx);
    tx_idle_pct = tx;
    rx_idle_pct <= rx;
  endtask

  // offer one word, predict once it is taken
  task automatic send_word(logic [7:0] c, logic eoi);
    while (idle_now(tx_idle_pct)) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.char_code    <= c;
    in_if.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
    parse_word(c, eoi);
  endtask

  // stop offering and wait until every expected word has come
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic push_byte(logic [7:0] c);
    line_text.push_back(c);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(4))
      0: return 8'h09;
      1: return 8'h0B;
      2: return 8'h0C;
      3: return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  task automatic push_blanks(int unsigned n);
    repeat (n) line_text.push_back(blank_char());
  endtask

  task automatic push_all_blanks();
    push_byte(8'h20);
    push_byte(8'h09);
    push_byte(8'h0B);
    push_byte(8'h0C);
    push_byte(8'h0D);
  endtask

  // any code but newline, optionally no hash either
  task automatic push_garbage(int unsigned n, bit no_hash);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom_range(255)); while (c == CH_NL || (no_hash && c == CH_HASH));
      line_text.push_back(c);
    end
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    if ($urandom_range(1)) return 8'h61 + (n - 4'd10);
    return 8'h41 + (n - 4'd10);
  endfunction

  function automatic logic [7:0] bad_char(bit at_start);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (digit_value(c) < 16 || is_blank(c) || c == CH_HASH ||
           (at_start && c == CH_DOLLAR));
    return c;
  endfunction

  task automatic push_random_hex(int unsigned n);
    repeat (n) line_text.push_back(hex_char(4'($urandom_range(15))));
  endtask

  task automatic push_counter(int unsigned v);
    for (int s = 12; s >= 0; s -= 4) line_text.push_back(hex_char(4'(v >> s)));
  endtask

  // comment text after a hash that must not turn the line into a header
  task automatic push_comment_tail();
    logic [7:0] c;
    if ($urandom_range(4) != 0) begin
      do c = 8'($urandom_range(255)); while (c == CH_NL || c == CH_DOLLAR);
      line_text.push_back(c);
      push_garbage($urandom_range(0, 10), 1'b0);
    end
  endtask

  // next record in sequence with optional framing
  task automatic build_record_line();
    push_blanks($urandom_range(0, 3));
    push_random_hex(LINE_CHARS - 4);
    push_counter(record_no);
    record_no++;
    push_blanks($urandom_range(0, 3));
    if ($urandom_range(3) == 0) begin
      push_byte(CH_HASH);
      push_comment_tail();
    end
  endtask

  // send the built line, closed by newline or by end of input
  task automatic send_line(bit by_eoi);
    foreach (line_text[i]) send_word(line_text[i], 1'b0);
    line_text.delete();
    if (by_eoi) send_word(8'($urandom_range(255)), 1'b1);
    else send_word(CH_NL, 1'b0);
  endtask

  task automatic send_random_line();
    int unsigned kind;
    bit          by_eoi;
    kind   = $urandom_range(99);
    by_eoi = ($urandom_range(9) == 0);
    if (kind < 60) begin
      build_record_line();
    end else if (kind < 70) begin
      // header mark, sometimes after arbitrary text
      if ($urandom_range(1)) push_garbage($urandom_range(1, 8), 1'b1);
      push_byte(CH_HASH);
      push_byte(CH_DOLLAR);
      push_garbage($urandom_range(0, 10), 1'b0);
    end else if (kind < 78) begin
      push_byte(CH_DOLLAR);
      push_garbage($urandom_range(0, 12), 1'b1);
    end else if (kind < 86) begin
      push_blanks($urandom_range(0, 4));
    end else begin
      push_blanks($urandom_range(0, 2));
      push_byte(CH_HASH);
      push_comment_tail();
    end
    send_line(by_eoi);
    // a repeated end of input finds nothing pending
    if (by_eoi && $urandom_range(3) == 0) send_word(8'($urandom_range(255)), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_lines();
    set_idling(12, 63);
    // every digit form, both byte extremes, framed by every blank code
    push_all_blanks();
    push_text("00FFffA50123456789abcdefABCDEF5a7e96");
    push_counter(record_no);
    record_no++;
    push_all_blanks();
    send_line(1'b0);
    // header line with high codes in it
    push_text("#$");
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h00);
    push_text("A1");
    send_line(1'b0);
    // text before the header mark is skipped too
    push_text("12 34 zz#$ rest");
    send_line(1'b0);
    // leading dollar with no comment
    push_text("$HDR 7f");
    push_byte(8'hFE);
    send_line(1'b0);
    // empty, blank-only and comment-only lines
    send_line(1'b0);
    push_all_blanks();
    send_line(1'b0);
    push_text("  # note $");
    send_line(1'b0);
    push_text("##$x");
    send_line(1'b0);
    push_text("#");
    send_line(1'b0);
    // record with trailing comment, closed by end of input
    push_byte(8'h20);
    repeat (LINE_CHARS - 4) push_byte(8'h46);
    push_counter(record_no);
    record_no++;
    push_text(" # end");
    push_byte(8'hFF);
    send_line(1'b1);
    // end of input with nothing pending
    send_word(CH_NL, 1'b1);
    // blanks closed by end of input
    push_all_blanks();
    send_line(1'b1);
    // lower-case record
    push_text("deadbeefcafe0123456789abcdef00ff0a0b");
    push_counter(record_no);
    record_no++;
    send_line(1'b0);
  endtask

  task automatic test_random_traffic(int unsigned tx, int unsigned rx);
    int unsigned start;
    set_idling(tx, rx);
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) send_random_line();
  endtask

  // result side held off while records keep coming, input must stall
  task automatic test_output_stall();
    set_idling(0, 0);
    fork
      begin
        stall_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        stall_rx <= 1'b0;
      end
    join_none
    repeat (6) begin
      build_record_line();
      send_line(1'b0);
    end
    wait_results_drained();
  endtask

  // sender goes quiet until the parser has drained
  task automatic test_paused_sender();
    set_idling(12, 63);
    repeat (2) begin
      build_record_line();
      send_line(1'b0);
    end
    wait_results_drained();
    send_random_line();
    build_record_line();
    send_line(1'b0);
    wait_results_drained();
  endtask

  // one faulty line, then the parser ignores everything
  task automatic test_fault_halts_parser();
    line_fault_e fault;
    int unsigned n;
    int unsigned p;
    set_idling(12, 63);
    fault = line_fault_e'($urandom_range(4));
    case (fault)
      FAULT_SHORT: begin
        n = $urandom_range(1, LINE_CHARS - 1);
        push_random_hex(n);
        // length wins over a bad character
        if ($urandom_range(1)) begin
          p = $urandom_range(0, n - 1);
          line_text[p] = bad_char(p == 0);
        end
      end
      FAULT_LONG: begin
        push_random_hex($urandom_range(LINE_CHARS + 1, LINE_CHARS + 30));
      end
      FAULT_INNER_BLANK: begin
        push_random_hex(LINE_CHARS - 4);
        push_counter(record_no);
        line_text[$urandom_range(1, LINE_CHARS - 2)] = blank_char();
      end
      FAULT_BAD_CHAR: begin
        push_random_hex(LINE_CHARS - 4);
        push_counter(record_no);
        p = $urandom_range(0, LINE_CHARS - 1);
        line_text[p] = bad_char(p == 0);
        if ($urandom_range(1)) line_text[$urandom_range(1, LINE_CHARS - 1)] = bad_char(1'b0);
      end
      default: begin
        push_random_hex(LINE_CHARS - 4);
        push_counter((record_no + $urandom_range(1, 16'hFFFF)) & 16'hFFFF);
      end
    endcase
    send_line($urandom_range(3) == 0);
    // halted: further lines give nothing
    build_record_line();
    send_line(1'b0);
    send_random_line();
    send_word(8'($urandom_range(255)), 1'b1);
    wait_results_drained();
  endtask

  initial begin
    rst_ni             = 1'b0;
    stall_rx           = 1'b0;
    in_if.valid        = 1'b0;
    in_if.char_code    = '0;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;
    cycle_count        = 0;
    mismatch_count     = 0;
    words_sent         = 0;
    record_no          = 0;
    tx_idle_pct        = 0;
    rx_idle_pct        = 0;
    reset_prediction();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_lines();
    test_random_traffic(12, 63);
    test_output_stall();
    test_random_traffic(63, 12);
    test_paused_sender();
    test_random_traffic(0, 0);
    test_fault_halts_parser();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
